// ----- hdl/assert_macros.svh -----
// Assertion macros for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every sampled edge.
`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
// Antecedent in one cycle implies consequent in the next.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ----- hdl/dqh_pkg.sv -----
// Types and constants of the detection qualifier.
package dqh_pkg;

  localparam int DIM_BITS_DEF = 16;
  localparam int DIM_FIELD_W  = 16;
  localparam int RATIO_W      = 17;
  localparam int CFG_DATA_W   = 32;
  localparam int CFG_IDX_W    = 3;

  // pass modes; the unused code behaves as no frame
  localparam logic [1:0] MODE_NONE  = 2'd0;
  localparam logic [1:0] MODE_FRAME = 2'd1;
  localparam logic [1:0] MODE_BAD   = 2'd2;

  localparam logic [2:0] CLASS_UNSPEC = 3'd0;
  localparam logic [2:0] CLASS_FIRST  = 3'd1;
  localparam logic [2:0] CLASS_LAST   = 3'd4;

  localparam logic [31:0] CONF_ONE_BITS = 32'h3F80_0000;
  localparam logic [31:0] CONF_NEG_ZERO = 32'h8000_0000;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_REQ_CONSEC = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINK_TMO   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_W      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_H      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_AREA   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_AREA   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FLASH_EN   = 3'd7;

  localparam logic [7:0]         RST_REQ_CONSEC = 8'd3;
  localparam logic [31:0]        RST_LINK_TMO   = 32'd1000;
  localparam logic [31:0]        RST_HOLD       = 32'd500;
  localparam logic [RATIO_W-1:0] RST_MAX_AREA   = 17'd65536;

  typedef struct packed {
    logic [1:0]             mode;
    logic [31:0]            now;
    logic                   detected;
    logic [2:0]             target_class;
    logic                   has_box;
    logic [DIM_FIELD_W-1:0] img_width;
    logic [DIM_FIELD_W-1:0] img_height;
    logic [DIM_FIELD_W-1:0] box_left;
    logic [DIM_FIELD_W-1:0] box_top;
    logic [DIM_FIELD_W-1:0] box_width;
    logic [DIM_FIELD_W-1:0] box_height;
    logic [31:0]            confidence_bits;
  } in_item_t;

  typedef struct packed {
    logic frame_accepted;
    logic link_up;
    logic target_seen;
    logic flash_pulse;
  } out_item_t;

endpackage

// ----- hdl/detection_qualifier_with_hold.sv -----
// Detection qualifier with link liveness, seen hold and flash pulse.
// An accepted item runs steps 0 to 6 and its result is registered at step 6;
// no new item is taken before then. One 17x(2*DIM_BITS) multiplier, shared,
//   forms six products in turn (image area, box area, four ratio bounds).
// in_stall is high during reset and while an item is in work; a result left
//   waiting holds the next item at its last step until the result is taken.
// Reset (rst, synchronous): registers to defaults, run/seen/link/times cleared.
module detection_qualifier_with_hold
  import dqh_pkg::*;
#(
  parameter int DIM_BITS = DIM_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

`include "assert_macros.svh"

  localparam int AW = 2 * DIM_BITS;       // area width
  localparam int PW = AW + RATIO_W;       // product width
  localparam logic [2:0] LAST_STEP = 3'd6;

  typedef enum logic {ST_IDLE, ST_CALC} state_t;

  // ---------------- configuration registers ----------------
  logic [7:0]         req_consec;
  logic [31:0]        link_tmo;
  logic [31:0]        hold_ticks;
  logic [RATIO_W-1:0] min_w;
  logic [RATIO_W-1:0] min_h;
  logic [RATIO_W-1:0] min_area;
  logic [RATIO_W-1:0] max_area;
  logic               flash_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_consec <= RST_REQ_CONSEC;
      link_tmo   <= RST_LINK_TMO;
      hold_ticks <= RST_HOLD;
      min_w      <= '0;
      min_h      <= '0;
      min_area   <= '0;
      max_area   <= RST_MAX_AREA;
      flash_en   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_REQ_CONSEC: req_consec <= cfg_data[7:0];
        REG_LINK_TMO:   link_tmo   <= cfg_data;
        REG_HOLD:       hold_ticks <= cfg_data;
        REG_MIN_W:      min_w      <= cfg_data[RATIO_W-1:0];
        REG_MIN_H:      min_h      <= cfg_data[RATIO_W-1:0];
        REG_MIN_AREA:   min_area   <= cfg_data[RATIO_W-1:0];
        REG_MAX_AREA:   max_area   <= cfg_data[RATIO_W-1:0];
        REG_FLASH_EN:   flash_en   <= cfg_data[0];
        default:        ;
      endcase
    end
  end

  // ---------------- sequencer and datapath ----------------
  state_t             state;
  logic [2:0]         step;
  in_item_t           item;          // captured item
  logic [PW-1:0]      prod;          // shared multiplier output register
  logic [AW-1:0]      img_area;
  logic [AW-1:0]      box_area;
  logic               ratio_ok;      // min width / height / area so far
  logic               basic_ok;      // all checks that need no product

  // dynamic state of the qualifier
  logic [7:0]  positive_run;
  logic        seen_flag;
  logic        prev_seen_flag;
  logic        link_flag;
  logic [31:0] last_valid_time;
  logic [31:0] last_positive_time;

  // dimensions masked to DIM_BITS
  logic [DIM_BITS-1:0] iw, ih, bx, by, bw, bh;
  assign iw = item.img_width[DIM_BITS-1:0];
  assign ih = item.img_height[DIM_BITS-1:0];
  assign bx = item.box_left[DIM_BITS-1:0];
  assign by = item.box_top[DIM_BITS-1:0];
  assign bw = item.box_width[DIM_BITS-1:0];
  assign bh = item.box_height[DIM_BITS-1:0];

  logic accept_in;
  logic finish;
  assign in_stall  = rst || (state != ST_IDLE);
  assign accept_in = in_valid && !in_stall;
  assign finish    = (state == ST_CALC) && (step == LAST_STEP) &&
                     (!out_valid || !out_stall);

  // operand select for the shared multiplier
  logic [RATIO_W-1:0] op_a;
  logic [AW-1:0]      op_b;
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (step)
      3'd0: begin
        op_a = {{(RATIO_W-DIM_BITS){1'b0}}, iw};
        op_b = {{DIM_BITS{1'b0}}, ih};
      end
      3'd1: begin
        op_a = {{(RATIO_W-DIM_BITS){1'b0}}, bw};
        op_b = {{DIM_BITS{1'b0}}, bh};
      end
      3'd2: begin
        op_a = min_w;
        op_b = {{DIM_BITS{1'b0}}, iw};
      end
      3'd3: begin
        op_a = min_h;
        op_b = {{DIM_BITS{1'b0}}, ih};
      end
      3'd4: begin
        op_a = min_area;
        op_b = img_area;
      end
      3'd5: begin
        op_a = max_area;
        op_b = img_area;
      end
      default: ;
    endcase
  end

  // scaled box terms for the Q16 compares
  logic [PW-1:0] bw_q16, bh_q16, area_q16;
  assign bw_q16   = {{(PW-DIM_BITS-16){1'b0}}, bw, 16'b0};
  assign bh_q16   = {{(PW-DIM_BITS-16){1'b0}}, bh, 16'b0};
  assign area_q16 = {1'b0, box_area, 16'b0};

  // checks that need no multiplication
  logic conf_ok, cls_ok, box_in, basic_now;
  logic [DIM_BITS:0] x_end, y_end;
  assign conf_ok = (item.confidence_bits <= CONF_ONE_BITS) ||
                   (item.confidence_bits == CONF_NEG_ZERO);
  assign cls_ok  = (item.target_class >= CLASS_FIRST) &&
                   (item.target_class <= CLASS_LAST);
  assign x_end   = {1'b0, bx} + {1'b0, bw};
  assign y_end   = {1'b0, by} + {1'b0, bh};
  assign box_in  = (bx < iw) && (by < ih) &&
                   (x_end <= {1'b0, iw}) && (y_end <= {1'b0, ih});
  always_comb begin
    if ((iw == '0) || (ih == '0)) begin
      basic_now = 1'b0;
    end else if (!item.detected) begin
      basic_now = (item.target_class == CLASS_UNSPEC);
    end else begin
      basic_now = conf_ok && item.has_box && cls_ok &&
                  (bw != '0) && (bh != '0) && box_in;
    end
  end

  // ---------------- end-of-pass update ----------------
  logic        frame_ok, accepted, is_frame, is_bad;
  logic [7:0]  run_upd;
  logic        seen_upd, link_upd, seen_fin, link_fin, flash;
  logic [31:0] lvt_upd, lpt_upd, dt_link, dt_pos;

  always_comb begin
    is_frame = (item.mode == MODE_FRAME);
    is_bad   = (item.mode == MODE_BAD);
    frame_ok = basic_ok && (!item.detected || (ratio_ok && (area_q16 <= prod)));
    accepted = is_frame && frame_ok;

    run_upd  = positive_run;
    seen_upd = seen_flag;
    link_upd = link_flag;
    lvt_upd  = last_valid_time;
    lpt_upd  = last_positive_time;
    if (accepted) begin
      lvt_upd  = item.now;
      link_upd = 1'b1;
      if (item.detected) begin
        if (positive_run < req_consec) begin
          run_upd = positive_run + 8'd1;
        end
        lpt_upd = item.now;
        if (run_upd >= req_consec) begin
          seen_upd = 1'b1;
        end
      end else begin
        run_upd = '0;
      end
    end else if (is_frame || is_bad) begin
      run_upd = '0;
    end

    // link timeout, then seen hold expiry
    dt_link  = item.now - lvt_upd;
    dt_pos   = item.now - lpt_upd;
    link_fin = link_upd && !(dt_link >= link_tmo);
    seen_fin = seen_upd && link_fin && !(dt_pos >= hold_ticks);
    flash    = flash_en && seen_fin && !prev_seen_flag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_IDLE;
      step               <= '0;
      out_valid          <= 1'b0;
      positive_run       <= '0;
      seen_flag          <= 1'b0;
      prev_seen_flag     <= 1'b0;
      link_flag          <= 1'b0;
      last_valid_time    <= '0;
      last_positive_time <= '0;
    end else begin
      // a new result in the same cycle keeps valid up
      if (out_valid && !out_stall && !finish) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept_in) begin
            item  <= in_item;
            step  <= '0;
            state <= ST_CALC;
          end
        end
        ST_CALC: begin
          if (step != LAST_STEP) begin
            prod <= PW'(op_a * op_b);
            step <= step + 3'd1;
          end
          // consume the product issued in the previous step; step 0 latches the basic checks
          unique case (step)
            3'd0: basic_ok <= basic_now;
            3'd1: begin
              img_area <= prod[AW-1:0];
              ratio_ok <= 1'b1;
            end
            3'd2: box_area <= prod[AW-1:0];
            3'd3: ratio_ok <= ratio_ok && (bw_q16 >= prod);
            3'd4: ratio_ok <= ratio_ok && (bh_q16 >= prod);
            3'd5: ratio_ok <= ratio_ok && (area_q16 >= prod);
            default: ;
          endcase
          if (finish) begin
            positive_run       <= run_upd;
            seen_flag          <= seen_fin;
            prev_seen_flag     <= seen_fin;
            link_flag          <= link_fin;
            last_valid_time    <= lvt_upd;
            last_positive_time <= lpt_upd;
            out_item           <= '{frame_accepted: accepted, link_up: link_fin,
                                    target_seen: seen_fin, flash_pulse: flash};
            out_valid          <= 1'b1;
            state              <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // ---------------- assertions ----------------
  `ASSERT_NEXT(a_accept_starts, clk, rst, accept_in, (state == ST_CALC) && (step == 3'd0), "bad start")
  `ASSERT_ALWAYS(a_step_range, clk, rst, (state != ST_CALC) || (step <= LAST_STEP), "step out of range")
  `ASSERT_ALWAYS(a_seen_needs_link, clk, rst, !seen_flag || link_flag, "seen while link down")
  `ASSERT_ALWAYS(a_flash_seen, clk, rst, !out_valid || !out_item.flash_pulse || out_item.target_seen, "flash, no seen")

endmodule
